/* hdl/edge_coverage_morris_counter_assert.svh */
// assertion macros for the checker file
`ifndef EDGE_COVERAGE_MORRIS_COUNTER_ASSERT_SVH
`define EDGE_COVERAGE_MORRIS_COUNTER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define ECMC_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define ECMC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/ecmc_pkg.sv */
// ----------------------------------------------------------------------------
// ecmc_pkg
// shared widths, command codes, fsm states and the morris threshold table
// ----------------------------------------------------------------------------
package ecmc_pkg;

	localparam int unsigned MAP_ENTRIES_DEF  = 65536;
	localparam int unsigned COUNTER_BITS_DEF = 8;

	localparam int CMD_W    = 2;
	localparam int LOC_W    = 32;
	localparam int IDX_W    = 16;
	localparam int CNT_W    = 8;
	localparam int LOG2_W   = 5;
	localparam int PREV_W   = 16;
	localparam int RNG_W    = 32;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// register select is the word address bit
	localparam logic REG_MAP_ENABLE = 1'b0;
	localparam logic REG_MAP_SIZE   = 1'b1;

	localparam logic [LOG2_W-1:0] MAP_LOG2_MIN   = 5'd1;
	localparam logic [LOG2_W-1:0] MAP_LOG2_MAX   = 5'd16;
	localparam logic [LOG2_W-1:0] MAP_LOG2_RESET = 5'd16;

	localparam logic [RNG_W-1:0] RNG_SEED = 32'h2545F491;
	localparam int RNG_SHL_A = 13;
	localparam int RNG_SHR_B = 17;
	localparam int RNG_SHL_C = 5;

	localparam int unsigned MORRIS_NUM = 30;
	localparam int unsigned MORRIS_DEN = 31;
	localparam int THR_DEPTH = 256;

	typedef logic [THR_DEPTH-1:0][RNG_W-1:0] thr_table_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_RMW
	} ecmc_state_t;

	// t[0] = all ones, t[i] = floor(t[i-1] * 30 / 31), worked out at elaboration
	function automatic thr_table_t build_thresholds();
		thr_table_t t;
		logic [63:0] p;
		t[0] = '1;
		for (int i = 1; i < THR_DEPTH; i++) begin
			p    = 64'(t[i-1]) * 64'(MORRIS_NUM);
			t[i] = 32'(p / 64'(MORRIS_DEN));
		end
		return t;
	endfunction

	localparam thr_table_t MORRIS_THRESH = build_thresholds();

endpackage

/* hdl/ecmc_in_if.sv */
// ----------------------------------------------------------------------------
// ecmc_in_if
// command channel: edge, clear or read item with its location
// ----------------------------------------------------------------------------
interface ecmc_in_if;
	import ecmc_pkg::*;

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [LOC_W-1:0] location;

	modport source (output valid, cmd, location, input ready);
	modport sink   (input valid, cmd, location, output ready);
endinterface

/* hdl/ecmc_out_if.sv */
// ----------------------------------------------------------------------------
// ecmc_out_if
// result channel: one item per command
// ----------------------------------------------------------------------------
interface ecmc_out_if;
	import ecmc_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] entry_index;
	logic [CNT_W-1:0] count_before;
	logic [CNT_W-1:0] count_after;
	logic             bumped;
	logic             ignored;

	modport source (output valid, entry_index, count_before, count_after, bumped, ignored,
		input ready);
	modport sink   (input valid, entry_index, count_before, count_after, bumped, ignored,
		output ready);
endinterface

/* hdl/edge_coverage_morris_counter.sv */
// ----------------------------------------------------------------------------
// edge_coverage_morris_counter: edge-coverage bitmap of morris counters
// edge, read, unknown and map-off clear items: memory read, then update and result
// clear with map on: counters in use zeroed one per cycle on the write port, then a result
// reset: zeroing sweep of all MAP_ENTRIES counters, no item taken until done; config writes always taken
// ----------------------------------------------------------------------------
module edge_coverage_morris_counter #(
	parameter int unsigned MAP_ENTRIES  = ecmc_pkg::MAP_ENTRIES_DEF,
	parameter int unsigned COUNTER_BITS = ecmc_pkg::COUNTER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ecmc_in_if.sink                           edge_in,
	ecmc_out_if.source                        result_out,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ecmc_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ecmc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ecmc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import ecmc_pkg::*;

	// counter address width and limits
	localparam int AW = $clog2(MAP_ENTRIES);
	localparam logic [AW-1:0]           LAST_ENTRY = AW'(MAP_ENTRIES - 1);
	localparam logic [IDX_W:0]          ENTRIES_W  = (IDX_W + 1)'(MAP_ENTRIES);
	localparam logic [COUNTER_BITS-1:0] COUNT_MAX  = '1;

	// xorshift32 step
	function automatic logic [RNG_W-1:0] xorshift32(input logic [RNG_W-1:0] x);
		logic [RNG_W-1:0] a;
		logic [RNG_W-1:0] b;
		a = x ^ (x << RNG_SHL_A);
		b = a ^ (a >> RNG_SHR_B);
		return b ^ (b << RNG_SHL_C);
	endfunction

	// ------------------------------------------------------------------
	// configuration registers on the apb port
	// ------------------------------------------------------------------
	logic              map_enable_q;
	logic [LOG2_W-1:0] map_size_log2_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_enable_q    <= 1'b0;
			map_size_log2_q <= MAP_LOG2_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAP_ENABLE: map_enable_q    <= pwdata[0];
				REG_MAP_SIZE:   map_size_log2_q <= pwdata[LOG2_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAP_ENABLE: prdata = APB_DATA_W'(map_enable_q);
			REG_MAP_SIZE:   prdata = APB_DATA_W'(map_size_log2_q);
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// index mask: log2 saturated to 1..16, size capped at MAP_ENTRIES
	// ------------------------------------------------------------------
	logic [LOG2_W-1:0] size_log2;
	logic [IDX_W:0]    map_size;
	logic [IDX_W-1:0]  index_mask;
	logic [AW-1:0]     last_in_use;

	always_comb begin
		size_log2 = map_size_log2_q;
		if (size_log2 < MAP_LOG2_MIN) size_log2 = MAP_LOG2_MIN;
		if (size_log2 > MAP_LOG2_MAX) size_log2 = MAP_LOG2_MAX;
		map_size = (IDX_W + 1)'(1) << size_log2;
		if (map_size > ENTRIES_W) map_size = ENTRIES_W;
		index_mask  = IDX_W'(map_size - (IDX_W + 1)'(1));
		last_in_use = index_mask[AW-1:0];
	end

	// ------------------------------------------------------------------
	// counter memory: one write port, one read port, registered read data
	// ------------------------------------------------------------------
	logic [COUNTER_BITS-1:0] hit_mem [MAP_ENTRIES];
	logic [COUNTER_BITS-1:0] rd_data_q;
	logic                    mem_re;
	logic                    mem_we;
	logic [AW-1:0]           mem_raddr;
	logic [AW-1:0]           mem_waddr;
	logic [COUNTER_BITS-1:0] mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) hit_mem[mem_waddr] <= mem_wdata;
	end

	// read data holds until the next read, so a stalled update keeps its operand
	always_ff @(posedge clk) begin
		if (mem_re) rd_data_q <= hit_mem[mem_raddr];
	end

	// ------------------------------------------------------------------
	// accept side: hash the index, launch the read, latch the item
	// ------------------------------------------------------------------
	ecmc_state_t       state_q;
	ecmc_state_t       state_d;
	logic              in_ready;
	logic              accept;
	logic [PREV_W-1:0] prev_loc_q;
	logic [IDX_W-1:0]  hash_idx;
	logic [IDX_W-1:0]  read_idx;

	assign edge_in.ready = in_ready;
	assign accept        = in_ready & edge_in.valid;

	// edge index mixes the previous location, read index takes the low bits alone
	assign hash_idx  = (prev_loc_q ^ edge_in.location[IDX_W-1:0]) & index_mask;
	assign read_idx  = edge_in.location[IDX_W-1:0] & index_mask;
	assign mem_raddr = (edge_in.cmd == CMD_READ) ? read_idx[AW-1:0] : hash_idx[AW-1:0];

	logic [CMD_W-1:0] cmd_s1;
	logic [AW-1:0]    idx_s1;
	logic             zero_loc_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= edge_in.cmd;
			idx_s1      <= mem_raddr;
			zero_loc_s1 <= (edge_in.location == '0);
		end
	end

	// previous location moves at accept; the next hash happens no earlier than
	// the following accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_loc_q <= '0;
		end else if (accept) begin
			if (edge_in.cmd == CMD_EDGE && edge_in.location != '0) begin
				prev_loc_q <= edge_in.location[PREV_W:1];
			end else if (edge_in.cmd == CMD_CLEAR) begin
				prev_loc_q <= '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// update stage: morris draw on the counter just read
	// ------------------------------------------------------------------
	logic [RNG_W-1:0]        rng_q;
	logic [RNG_W-1:0]        rng_next;
	logic [RNG_W-1:0]        threshold;
	logic                    is_edge;
	logic                    is_read;
	logic                    do_draw;
	logic                    bump;
	logic [COUNTER_BITS-1:0] cnt_after;

	assign is_edge   = (cmd_s1 == CMD_EDGE) & ~zero_loc_s1;
	assign is_read   = (cmd_s1 == CMD_READ);
	assign do_draw   = is_edge & map_enable_q & (rd_data_q != COUNT_MAX);
	assign rng_next  = xorshift32(rng_q);
	assign threshold = MORRIS_THRESH[CNT_W'(rd_data_q)];
	assign bump      = do_draw & (rng_next < threshold);
	assign cnt_after = bump ? COUNTER_BITS'(rd_data_q + 1'b1) : rd_data_q;

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	logic             out_valid_q;
	logic             out_free;
	logic             load_out;
	logic [IDX_W-1:0] out_index_q;
	logic [CNT_W-1:0] out_before_q;
	logic [CNT_W-1:0] out_after_q;
	logic             out_bumped_q;
	logic             out_ignored_q;

	assign out_free = ~out_valid_q | result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// clear and unknown commands report all zeros, zero-location edges only the flag
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_index_q   <= (is_edge | is_read) ? IDX_W'(idx_s1) : '0;
			out_before_q  <= (is_edge | is_read) ? CNT_W'(rd_data_q) : '0;
			out_after_q   <= (is_edge | is_read) ? CNT_W'(cnt_after) : '0;
			out_bumped_q  <= bump;
			out_ignored_q <= (cmd_s1 == CMD_EDGE) & zero_loc_s1;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.entry_index  = out_index_q;
	assign result_out.count_before = out_before_q;
	assign result_out.count_after  = out_after_q;
	assign result_out.bumped       = out_bumped_q;
	assign result_out.ignored      = out_ignored_q;

	// ------------------------------------------------------------------
	// random state and sweep pointer
	// ------------------------------------------------------------------
	logic          rng_adv;
	logic [AW-1:0] sweep_ptr_q;
	logic          sweep_clr;
	logic          sweep_inc;

	// generator only steps when a draw is actually made
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q <= RNG_SEED;
		end else if (rng_adv) begin
			rng_q <= rng_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_ptr_q <= '0;
		end else if (sweep_clr) begin
			sweep_ptr_q <= '0;
		end else if (sweep_inc) begin
			sweep_ptr_q <= AW'(sweep_ptr_q + 1'b1);
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// init : zero every counter after reset
	// idle : take an item and launch its read
	// clear: zero the counters in use, one a cycle
	// rmw  : draw, write back, hand the result to the output register;
	//        waits here while the output register is full and stalled
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = sweep_ptr_q;
		mem_wdata = '0;
		sweep_clr = 1'b0;
		sweep_inc = 1'b0;
		load_out  = 1'b0;
		rng_adv   = 1'b0;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				sweep_inc = 1'b1;
				if (sweep_ptr_q == LAST_ENTRY) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (edge_in.valid) begin
					mem_re = 1'b1;
					if (edge_in.cmd == CMD_CLEAR && map_enable_q) begin
						sweep_clr = 1'b1;
						state_d   = ST_CLEAR;
					end else begin
						state_d = ST_RMW;
					end
				end
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				sweep_inc = 1'b1;
				if (sweep_ptr_q == last_in_use) state_d = ST_RMW;
			end
			ST_RMW: begin
				if (out_free) begin
					load_out  = 1'b1;
					rng_adv   = do_draw;
					mem_we    = bump;
					mem_waddr = idx_s1;
					mem_wdata = cnt_after;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/ecmc_checker.sv */
// ----------------------------------------------------------------------------
// ecmc_checker
// port-level checks on the morris counter bitmap, bound to the top level
// ----------------------------------------------------------------------------
`include "edge_coverage_morris_counter_assert.svh"

module ecmc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [ecmc_pkg::IDX_W-1:0]        out_entry_index,
	input logic [ecmc_pkg::CNT_W-1:0]        out_count_before,
	input logic [ecmc_pkg::CNT_W-1:0]        out_count_after,
	input logic                              out_bumped,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic [ecmc_pkg::APB_ADDR_W-1:0]   paddr,
	input logic [ecmc_pkg::APB_DATA_W-1:0]   pwdata,
	input logic [ecmc_pkg::APB_DATA_W-1:0]   prdata
);
	import ecmc_pkg::*;

	// one item at a time: ready drops right after an accept
	`ECMC_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "item accepted while busy")

	// a bump moves the counter up by exactly one
	`ECMC_ASSERT(a_bump_step, out_valid && out_bumped, out_count_after == out_count_before + 8'd1, "bump not a unit step")

	// stalled result holds
	`ECMC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_entry_index) && $stable(out_count_after), "stalled result changed")

	// map enable reads back what was written
	`ECMC_ASSERT(a_enable_readback, psel && !pwrite && paddr[2] == REG_MAP_ENABLE && $past(psel && penable && pwrite && paddr[2] == REG_MAP_ENABLE), prdata[0] == $past(pwdata[0]), "map enable readback mismatch")

endmodule

bind edge_coverage_morris_counter ecmc_checker u_ecmc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (edge_in.valid),
	.in_ready         (edge_in.ready),
	.out_valid        (result_out.valid),
	.out_ready        (result_out.ready),
	.out_entry_index  (result_out.entry_index),
	.out_count_before (result_out.count_before),
	.out_count_after  (result_out.count_after),
	.out_bumped       (result_out.bumped),
	.psel             (psel),
	.penable          (penable),
	.pwrite           (pwrite),
	.paddr            (paddr),
	.pwdata           (pwdata),
	.prdata           (prdata)
);

/* test/tb_edge_coverage_morris_counter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_edge_coverage_morris_counter
// drives edge, clear, read and unknown items into the coverage bitmap and
// checks every result item against a behavioural model of the morris counters
// kept in the bench, or typed directed results; covers a directed table, a full-rate
// burst on a single counter and randomised phases across several map settings
// ----------------------------------------------------------------------------
module tb_edge_coverage_morris_counter;
	import ecmc_pkg::*;

	// bench timing
	localparam int          HALF_PERIOD    = 10;
	localparam int          RESET_CYCLES   = 7;
	localparam int          HOLDOFF_CYCLES = 150;
	localparam int          TAIL_CYCLES    = 16;
	localparam int          RUN_LIMIT_NS   = 50_000_000;
	localparam int unsigned PRINT_CAP      = 200;

	// bitmap behaviour
	localparam int          MAP_SPAN   = 65536;
	localparam int          GROW_STEPS = 256;
	localparam logic [63:0] GROW_NUM   = 64'd30;
	localparam logic [63:0] GROW_DEN   = 64'd31;
	localparam logic [CNT_W-1:0] COUNT_TOP = '1;
	localparam logic [RNG_W-1:0] XS_SEED   = 32'h2545F491;
	localparam int XS_SHL_FIRST  = 13;
	localparam int XS_SHR        = 17;
	localparam int XS_SHL_SECOND = 5;

	// cmd value with no defined meaning
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	// burst: one location hammered at full rate so its counter climbs
	localparam logic [LOC_W-1:0] BURST_LOC      = 32'h0000_0006;
	localparam int               BURST_LOG2     = 3;
	localparam int unsigned      BURST_CAP      = 120;
	localparam int unsigned      BURST_OVERRUN  = 40;
	localparam int unsigned      BURST_READ_GAP = 30;

	localparam int PHASE_ITEMS = 195;

	typedef struct packed {
		logic [IDX_W-1:0] entry_index;
		logic [CNT_W-1:0] count_before;
		logic [CNT_W-1:0] count_after;
		logic             bumped;
		logic             ignored;
	} hit_result_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_REG
	} row_kind_t;

	// one line of the directed table; data is the location or the register value
	typedef struct packed {
		row_kind_t        kind;
		logic [CMD_W-1:0] op;
		logic             reg_sel;
		logic [LOC_W-1:0] data;
		logic             typed;
		hit_result_t      want;
	} dir_row_t;

	localparam hit_result_t ZERO_RES    = '0;
	localparam hit_result_t IGNORED_RES = '{16'h0, 8'h0, 8'h0, 1'b0, 1'b1};

	// typed rows hold results that follow straight from the rules, the rest
	// are worked out by the bitmap model
	localparam dir_row_t DIRECTED [29] = '{
		// map detached after reset, full 16-bit index
		'{ROW_ITEM, CMD_READ,    1'b0, 32'h0000_0000, 1'b1, ZERO_RES},
		'{ROW_ITEM, CMD_READ,    1'b0, 32'hFFFF_FFFF, 1'b1, '{16'hFFFF, 8'h0, 8'h0, 1'b0, 1'b0}},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'h0000_0000, 1'b1, IGNORED_RES},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'h0001_2345, 1'b1, '{16'h2345, 8'h0, 8'h0, 1'b0, 1'b0}},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'hFFFF_FFFF, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_CLEAR,   1'b0, 32'hFFFF_FFFF, 1'b1, ZERO_RES},
		'{ROW_ITEM, CMD_UNKNOWN, 1'b0, 32'hFFFF_FFFF, 1'b1, ZERO_RES},
		// attach a four-entry map and bump entry 1 repeatedly after a first edge to entry 2
		'{ROW_REG,  CMD_EDGE,    REG_MAP_ENABLE, 32'h1, 1'b0, ZERO_RES},
		'{ROW_REG,  CMD_EDGE,    REG_MAP_SIZE,   32'h2, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'h0000_0006, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'h0000_0006, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'h0000_0006, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'h0000_0006, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_READ,    1'b0, 32'h0000_0001, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'h0000_0000, 1'b1, IGNORED_RES},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'h8000_0000, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_CLEAR,   1'b0, 32'h0000_0000, 1'b1, ZERO_RES},
		'{ROW_ITEM, CMD_READ,    1'b0, 32'h0000_0001, 1'b1, '{16'h0001, 8'h0, 8'h0, 1'b0, 1'b0}},
		// size below range saturates to two entries
		'{ROW_REG,  CMD_EDGE,    REG_MAP_SIZE,   32'h0, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'hFFFF_FFFF, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_READ,    1'b0, 32'h0000_0005, 1'b0, ZERO_RES},
		// size above range saturates to the full map, then one full sweep
		'{ROW_REG,  CMD_EDGE,    REG_MAP_SIZE,   32'h1F, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'hABCD_1234, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'h5555_AAAA, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_CLEAR,   1'b0, 32'h0000_0000, 1'b1, ZERO_RES},
		'{ROW_ITEM, CMD_READ,    1'b0, 32'hFFFF_FFFF, 1'b1, '{16'hFFFF, 8'h0, 8'h0, 1'b0, 1'b0}},
		// detach again
		'{ROW_REG,  CMD_EDGE,    REG_MAP_ENABLE, 32'h0, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_EDGE,    1'b0, 32'h0000_0003, 1'b0, ZERO_RES},
		'{ROW_ITEM, CMD_UNKNOWN, 1'b0, 32'h0000_0000, 1'b1, ZERO_RES}
	};

	logic clk = 1'b0;
	logic arst_n;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	ecmc_in_if  edge_bus ();
	ecmc_out_if result_bus ();

	edge_coverage_morris_counter i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.edge_in    (edge_bus),
		.result_out (result_bus),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #HALF_PERIOD clk = ~clk;

	// bitmap model: counters, hash history, generator and the two registers
	logic [CNT_W-1:0]  hit_count [MAP_SPAN];
	logic [PREV_W-1:0] last_loc;
	logic [RNG_W-1:0]  xs_state;
	logic [RNG_W-1:0]  grow_limit [GROW_STEPS];
	logic              cfg_en;
	logic [LOG2_W-1:0] cfg_log2;

	// results still owed by the block, oldest first
	hit_result_t due_results [$];
	int unsigned bad_fields = 0;

	// idling switches and hold-off requests towards the result side
	bit          src_gaps = 1'b1;
	bit          sink_gaps = 1'b1;
	int unsigned holdoff_reqs = 0;

	// applies one item to the model and returns the result it should produce
	function automatic hit_result_t step_bitmap(input logic [CMD_W-1:0] op,
			input logic [LOC_W-1:0] loc);
		hit_result_t       r;
		logic [LOG2_W-1:0] lg;
		logic [IDX_W-1:0]  mask;
		logic [IDX_W-1:0]  idx;
		logic [RNG_W-1:0]  x;
		int                span;
		r  = '0;
		lg = cfg_log2;
		if (lg < MAP_LOG2_MIN)
			lg = MAP_LOG2_MIN;
		if (lg > MAP_LOG2_MAX)
			lg = MAP_LOG2_MAX;
		span = 1 << lg;
		mask = IDX_W'(span - 1);
		case (op)
			CMD_EDGE: begin
				if (loc == '0) begin
					r.ignored = 1'b1;
				end else begin
					idx = (last_loc ^ loc[IDX_W-1:0]) & mask;
					r.entry_index  = idx;
					r.count_before = hit_count[idx];
					r.count_after  = hit_count[idx];
					// a saturated counter takes no draw at all
					if (cfg_en && hit_count[idx] != COUNT_TOP) begin
						x = xs_state;
						x = x ^ (x << XS_SHL_FIRST);
						x = x ^ (x >> XS_SHR);
						x = x ^ (x << XS_SHL_SECOND);
						xs_state = x;
						if (x < grow_limit[hit_count[idx]]) begin
							hit_count[idx] = hit_count[idx] + 1'b1;
							r.count_after  = hit_count[idx];
							r.bumped       = 1'b1;
						end
					end
					last_loc = loc[PREV_W:1];
				end
			end
			CMD_CLEAR: begin
				if (cfg_en)
					for (int i = 0; i < span; i++)
						hit_count[i] = '0;
				last_loc = '0;
			end
			CMD_READ: begin
				idx = loc[IDX_W-1:0] & mask;
				r.entry_index  = idx;
				r.count_before = hit_count[idx];
				r.count_after  = hit_count[idx];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// offers one item, idling first now and then; the model is stepped at acceptance
	task automatic push_item(input logic [CMD_W-1:0] op, input logic [LOC_W-1:0] loc,
			input logic typed, input hit_result_t want);
		hit_result_t guess;
		while (src_gaps && $urandom_range(99) < 9) begin
			edge_bus.valid <= 1'b0;
			@(posedge clk);
		end
		edge_bus.valid    <= 1'b1;
		edge_bus.cmd      <= op;
		edge_bus.location <= loc;
		@(posedge clk);
		while (!edge_bus.ready)
			@(posedge clk);
		guess = step_bitmap(op, loc);
		due_results.push_back(typed ? want : guess);
	endtask

	// stop offering and wait until the block owes nothing
	task automatic settle();
		edge_bus.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// setup then access phase, register taken at the access edge, then back to idle
	task automatic reg_write(input logic sel, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({sel, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (sel == REG_MAP_ENABLE)
			cfg_en = value[0];
		else
			cfg_log2 = value[LOG2_W-1:0];
		@(posedge clk);
	endtask

	// one random phase under a fixed setting; squeeze adds a long result hold-off
	task automatic run_phase(input logic en, input logic [LOG2_W-1:0] lg,
			input bit squeeze);
		logic [LOC_W-1:0]      pool [6];
		logic [LOC_W-1:0]      loc;
		logic [CMD_W-1:0]      op;
		logic [APB_DATA_W-1:0] word;
		int unsigned           roll;
		settle();
		// junk in the upper bits must not matter
		word    = $urandom();
		word[0] = en;
		reg_write(REG_MAP_ENABLE, word);
		word              = $urandom();
		word[LOG2_W-1:0]  = lg;
		reg_write(REG_MAP_SIZE, word);
		// small ids collide often, wide ones exercise every location bit
		for (int k = 0; k < 6; k++)
			pool[k] = (k < 3) ? LOC_W'($urandom_range(63, 1)) : LOC_W'($urandom());
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (squeeze && i == 40)
				holdoff_reqs++;
			roll = $urandom_range(99);
			op   = CMD_EDGE;
			loc  = pool[$urandom_range(5)];
			if (roll < 4) begin
				loc = '0;
			end else if (roll < 48) begin
				// recurring edges so counters climb
			end else if (roll < 62) begin
				loc = $urandom();
			end else if (roll < 76) begin
				// aim reads at indices the pool edges hash to
				op  = CMD_READ;
				loc = pool[$urandom_range(5)] ^ (pool[$urandom_range(5)] >> 1);
			end else if (roll < 88) begin
				op  = CMD_READ;
				loc = $urandom();
			end else if (roll < 93) begin
				// a clear of a large attached map sweeps every counter in use, so it is sent as a read
				op  = (!cfg_en || cfg_log2 <= 10) ? CMD_CLEAR : CMD_READ;
				loc = $urandom();
			end else if (roll < 97) begin
				op  = CMD_UNKNOWN;
				loc = $urandom();
			end
			push_item(op, loc, 1'b0, ZERO_RES);
		end
	endtask

	task automatic flag_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		bad_fields++;
		if (bad_fields <= PRINT_CAP)
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
	endtask

	// result side: random stalls, plus a counted hold-off on request
	initial begin : result_sink
		int unsigned hold_left;
		int unsigned seen;
		hold_left        = 0;
		seen             = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (seen != holdoff_reqs) begin
				seen      = holdoff_reqs;
				hold_left = HOLDOFF_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= !(sink_gaps && $urandom_range(99) < 9);
			end
		end
	end

	// every accepted result item against the oldest owed one
	always @(posedge clk) begin : result_check
		hit_result_t want;
		hit_result_t got;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			got.entry_index  = result_bus.entry_index;
			got.count_before = result_bus.count_before;
			got.count_after  = result_bus.count_after;
			got.bumped       = result_bus.bumped;
			got.ignored      = result_bus.ignored;
			if (due_results.size() == 0) begin
				bad_fields++;
				if (bad_fields <= PRINT_CAP)
					$display("%0t: result item with none expected, got %p", $time, got);
			end else begin
				want = due_results.pop_front();
				if (got.entry_index !== want.entry_index)
					flag_field("entry_index", 32'(want.entry_index),
						32'(got.entry_index));
				if (got.count_before !== want.count_before)
					flag_field("count_before", 32'(want.count_before),
						32'(got.count_before));
				if (got.count_after !== want.count_after)
					flag_field("count_after", 32'(want.count_after),
						32'(got.count_after));
				if (got.bumped !== want.bumped)
					flag_field("bumped", 32'(want.bumped), 32'(got.bumped));
				if (got.ignored !== want.ignored)
					flag_field("ignored", 32'(want.ignored), 32'(got.ignored));
			end
		end
	end

	initial begin : watchdog
		#RUN_LIMIT_NS;
		$display("tb_edge_coverage_morris_counter: errors");
		$finish;
	end

	initial begin : stimulus
		logic [IDX_W-1:0] burst_idx;
		int unsigned      sent;
		int unsigned      overrun;

		// every block input known from time zero
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		edge_bus.valid    = 1'b0;
		edge_bus.cmd      = CMD_EDGE;
		edge_bus.location = '0;

		// model state after reset
		foreach (hit_count[i])
			hit_count[i] = '0;
		last_loc      = '0;
		xs_state      = XS_SEED;
		cfg_en        = 1'b0;
		cfg_log2      = MAP_LOG2_RESET;
		grow_limit[0] = '1;
		for (int i = 1; i < GROW_STEPS; i++)
			grow_limit[i] = RNG_W'((64'(grow_limit[i-1]) * GROW_NUM) / GROW_DEN);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; the block holds off items until its clearing sweep ends
		for (int i = 0; i < $size(DIRECTED); i++) begin
			if (DIRECTED[i].kind == ROW_REG) begin
				settle();
				reg_write(DIRECTED[i].reg_sel, DIRECTED[i].data);
			end else begin
				push_item(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].typed,
					DIRECTED[i].want);
			end
		end

		// burst at full rate on both sides, with an occasional read
		settle();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		reg_write(REG_MAP_ENABLE, 32'h1);
		reg_write(REG_MAP_SIZE, BURST_LOG2);
		burst_idx = IDX_W'((BURST_LOC ^ (BURST_LOC >> 1)) & ((1 << BURST_LOG2) - 1));
		sent      = 0;
		overrun   = 0;
		while (overrun < BURST_OVERRUN && sent < BURST_CAP) begin
			push_item(CMD_EDGE, BURST_LOC, 1'b0, ZERO_RES);
			sent++;
			if (sent % BURST_READ_GAP == 0)
				push_item(CMD_READ, LOC_W'(burst_idx), 1'b0, ZERO_RES);
			if (hit_count[burst_idx] == COUNT_TOP)
				overrun++;
		end
		settle();
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;

		// random phases; each starts once the block owes nothing
		run_phase(1'b1, 5'd4, 1'b0);
		run_phase(1'b1, 5'd0, 1'b1);
		run_phase(1'b0, 5'd9, 1'b0);
		run_phase(1'b1, 5'd7, 1'b0);
		run_phase(1'b1, 5'd16, 1'b0);
		run_phase(1'b1, 5'd1, 1'b0);
		run_phase(1'b0, 5'd31, 1'b0);
		run_phase(1'b1, LOG2_W'($urandom_range(31)), 1'b0);

		// drain, then watch a little longer for stray result items
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_fields == 0)
			$display("tb_edge_coverage_morris_counter: clean");
		else
			$display("tb_edge_coverage_morris_counter: errors");
		$finish;
	end

endmodule
